### rtl/sieve_prime_counter_unit_assert.svh
// Assertion macros used by the checker of the sieve prime counter.
`ifndef SIEVE_PRIME_COUNTER_UNIT_ASSERT_SVH
`define SIEVE_PRIME_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sieve counter check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sieve counter check failed");

`endif

### rtl/spc_pkg.sv
// Shared types and constants of the sieve prime counter.
`default_nettype none
package spc_pkg;

  localparam int LIMIT_W     = 14;
  localparam int COUNT_W     = 11;
  localparam int FIRST_PRIME = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_BASE,
    ST_CHECK,
    ST_MARK,
    ST_SQ,
    ST_INC,
    ST_COUNT,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

### rtl/spc_adder.sv
// Shared address adder used by the fill, clear, square, increment and count steps of the sequencer.
`default_nettype none
module spc_adder #(
  parameter int W = 15
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] sum
);

  assign sum = a + b;

endmodule
`default_nettype wire

### rtl/spc_bitmem.sv
// One-bit-wide sieve store: one write port, one registered read port.
`default_nettype none
module spc_bitmem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/sieve_prime_counter_unit.sv
// Sieve prime counter for limit n: one item at a time, busy throughout, and a new limit is
// taken as early as the cycle that carries the result. The shared address adder and the
// sieve store (one write, one read port) give one entry per cycle in each of the fill,
// clear and count phases; the result strobe lasts one cycle and cannot be stalled.
// Reset (synchronous, active low) returns the sequencer to idle; the store is not cleared.
`default_nettype none
module sieve_prime_counter_unit #(
  parameter int SIEVE_DEPTH = 16384
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [spc_pkg::LIMIT_W-1:0]  in_limit,
  output logic                         out_valid,
  output logic [spc_pkg::COUNT_W-1:0]  out_prime_count
);

  // Address width of the store, and one extra bit so that j+i and the
  // square update cannot overflow before they are compared against n.
  localparam int AW = $clog2(SIEVE_DEPTH);
  localparam int CW = AW + 1;
  localparam int XW = (AW > spc_pkg::LIMIT_W) ? AW : spc_pkg::LIMIT_W;

  spc_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] n_r, n_nxt;        // saturated limit
  logic [CW-1:0] j_r, j_nxt;        // walking address: fill, multiples, count
  logic [CW-1:0] i_r, i_nxt;        // current base
  logic [CW-1:0] sq_r, sq_nxt;      // i*i, kept by incremental update
  logic [spc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [CW-1:0] add_a, add_b, add_sum;
  logic          mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic [XW-1:0] lim_x;
  logic [CW-1:0] lim_sat;

  // Clamp the limit to the last entry of the store.
  assign lim_x   = XW'(in_limit);
  assign lim_sat = (lim_x > XW'(SIEVE_DEPTH - 1)) ? CW'(SIEVE_DEPTH - 1) : CW'(lim_x);

  spc_adder #(.W(CW)) u_add (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  spc_bitmem #(.DEPTH(SIEVE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Base lookups read at i; fill, clear and count all walk with j.
  assign mem_waddr = j_r[AW-1:0];
  assign mem_raddr = (state_r == spc_pkg::ST_BASE) ? i_r[AW-1:0] : j_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spc_pkg::ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    j_r     <= j_nxt;
    i_r     <= i_nxt;
    sq_r    <= sq_nxt;
    count_r <= count_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    sq_nxt        = sq_r;
    count_nxt     = count_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    add_a         = j_r;
    add_b         = CW'(1);
    mem_we        = 1'b0;
    mem_wdata     = 1'b0;

    unique case (state_r)
      spc_pkg::ST_IDLE: begin
        if (start) begin
          n_nxt     = lim_sat;
          j_nxt     = '0;
          i_nxt     = CW'(spc_pkg::FIRST_PRIME);
          sq_nxt    = CW'(spc_pkg::FIRST_PRIME * spc_pkg::FIRST_PRIME);
          count_nxt = '0;
          state_nxt = spc_pkg::ST_FILL;
        end
      end

      // Mark entries 0..n as candidates.
      spc_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        if (j_r == n_r) begin
          state_nxt = spc_pkg::ST_BASE;
        end else begin
          j_nxt = add_sum;
        end
      end

      // Stop the base loop once i*i passes n; otherwise fetch entry i.
      spc_pkg::ST_BASE: begin
        if (sq_r > n_r) begin
          if (n_r < CW'(spc_pkg::FIRST_PRIME)) begin
            state_nxt = spc_pkg::ST_DRAIN;
          end else begin
            j_nxt     = CW'(spc_pkg::FIRST_PRIME);
            state_nxt = spc_pkg::ST_COUNT;
          end
        end else begin
          state_nxt = spc_pkg::ST_CHECK;
        end
      end

      spc_pkg::ST_CHECK: begin
        if (mem_rdata) begin
          j_nxt     = sq_r;
          state_nxt = spc_pkg::ST_MARK;
        end else begin
          state_nxt = spc_pkg::ST_SQ;
        end
      end

      // Clear i*i, i*i+i, ... up to n.
      spc_pkg::ST_MARK: begin
        mem_we = 1'b1;
        add_b  = i_r;
        if (add_sum > n_r) begin
          state_nxt = spc_pkg::ST_SQ;
        end else begin
          j_nxt = add_sum;
        end
      end

      // Advance the square: (i+1)^2 = i^2 + 2i + 1.
      spc_pkg::ST_SQ: begin
        add_a     = sq_r;
        add_b     = {i_r[CW-2:0], 1'b1};
        sq_nxt    = add_sum;
        state_nxt = spc_pkg::ST_INC;
      end

      spc_pkg::ST_INC: begin
        add_a     = i_r;
        i_nxt     = add_sum;
        state_nxt = spc_pkg::ST_BASE;
      end

      // Stream reads 2..n; each read bit is tallied in the following cycle.
      spc_pkg::ST_COUNT: begin
        rd_pend_nxt = 1'b1;
        count_nxt   = count_r + spc_pkg::COUNT_W'(rd_pend_r & mem_rdata);
        if (j_r == n_r) begin
          state_nxt = spc_pkg::ST_DRAIN;
        end else begin
          j_nxt = add_sum;
        end
      end

      // Tally the last read and present the result.
      spc_pkg::ST_DRAIN: begin
        count_nxt     = count_r + spc_pkg::COUNT_W'(rd_pend_r & mem_rdata);
        out_valid_nxt = 1'b1;
        state_nxt     = spc_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = spc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != spc_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_prime_count = count_r;

endmodule
`default_nettype wire

### rtl/spc_checker.sv
// Port-level checker for the sieve prime counter and its bind.
`default_nettype none
`include "sieve_prime_counter_unit_assert.svh"
module spc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [spc_pkg::LIMIT_W-1:0]  in_limit,
  input logic                         out_valid,
  input logic [spc_pkg::COUNT_W-1:0]  out_prime_count
);

  logic unused_ok;
  assign unused_ok = ^{in_limit, out_prime_count};

  // A result only shows as the block returns to idle.
  `SPC_ASSERT_NOW(a_result_when_idle, out_valid, !busy)
  // An accepted transfer keeps the block busy the next cycle.
  `SPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // The result strobe lasts exactly one cycle.
  `SPC_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

endmodule

bind sieve_prime_counter_unit spc_checker u_spc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_limit        (in_limit),
  .out_valid       (out_valid),
  .out_prime_count (out_prime_count)
);
`default_nettype wire
